// ===== hdl/bhs_pkg.sv =====
package bhs_pkg;

  localparam int KEY_W = 31;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  localparam int NUM_BUCKETS_DEF  = 10;
  localparam int BUCKET_DEPTH_DEF = 8;

  // request kinds
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // result status
  localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [ST_W-1:0] ST_ABSENT    = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

endpackage

// ===== hdl/bhs_ram.sv =====
module bhs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 80,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/bhs_mod.sv =====
// Remainder by a constant: reciprocal multiply, subtract, one corrective compare.
// The remainder is valid with done; start passes through ph1 and ph2 before done.
module bhs_mod
  import bhs_pkg::*;
#(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] dividend,
  output logic             done,
  output logic [BW-1:0]    rem
);

  // floor(2^31 / N): the quotient estimate is low by at most one
  localparam logic [31:0] RECIP = 32'((64'd1 << KEY_W) / NUM_BUCKETS);
  localparam int PW = KEY_W + 32;
  localparam int DW = $clog2(NUM_BUCKETS) + 2;

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] quo;
  logic [DW-1:0]    diff;
  logic [BW-1:0]    rem_r;
  logic             ph1;
  logic             ph2;

  assign rem = rem_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph1  <= 1'b0;
      ph2  <= 1'b0;
      done <= 1'b0;
    end else begin
      ph1  <= start;
      ph2  <= ph1;
      done <= ph2;
      if (start) begin
        key_r <= dividend;
        quo   <= KEY_W'((PW'(dividend) * PW'(RECIP)) >> KEY_W);
      end
      // only the low bits matter: the true difference is below 2*N
      if (ph1) begin
        diff <= DW'(key_r) - DW'(quo) * DW'(NUM_BUCKETS);
      end
      if (ph2) begin
        if (diff >= DW'(NUM_BUCKETS)) begin
          rem_r <= BW'(diff - DW'(NUM_BUCKETS));
        end else begin
          rem_r <= BW'(diff);
        end
      end
    end
  end

endmodule

// ===== hdl/bucketed_hash_set_core.sv =====
// Channel  Dir  Fields (low bit up)                      Handshake
// s_       in   s_tuser: op[1:0]; s_tdata: key[30:0]     s_tvalid/s_tready
// m_       out  m_tdata: was_present[0], status[2:1]     m_tvalid/m_tready
//
// A request passes from accept to m_tvalid through these steps: the remainder
// unit starts at accept and runs through its ph1 and ph2 registers, then S_DIV forms
// the bucket base, S_SCAN issues BUCKET_DEPTH slot reads and drains the read pipe,
// S_DECIDE decides and writes, and S_OUT loads the result. s_tready returns after
// the load, so a new request is accepted only once the last one is through. After
// reset a clearing pass writes every slot once while s_tready stays low. A result
// held by m_tready low does not stop the next request being accepted; that request
// waits in its result load state until the output register frees.
module bucketed_hash_set_core
  import bhs_pkg::*;
#(
  parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
  parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // key[30:0], zero pad [31]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // was_present[0], status[2:1], zero pad [7:3]
);

  localparam int SLOTS = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int IW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int CW    = $clog2(BUCKET_DEPTH + 1);
  localparam int EW    = KEY_W + 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIV, S_SCAN, S_DECIDE, S_OUT
  } state_t;

  state_t           state;
  logic [OP_W-1:0]  op_q;
  logic [KEY_W-1:0] key_q;
  logic [AW-1:0]    clr_addr;
  logic [AW-1:0]    base;
  logic [CW-1:0]    iss;
  logic             rd_pend;
  logic [IW-1:0]    rd_idx;
  logic             hit_found;
  logic [IW-1:0]    hit_idx;
  logic             free_found;
  logic [IW-1:0]    free_idx;
  logic             res_present;
  logic [ST_W-1:0]  res_status;

  logic             div_start;
  logic             div_done;
  logic [BW-1:0]    bucket;

  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  logic [EW-1:0]    ram_wr_data;
  logic             ram_rd_en;
  logic [AW-1:0]    ram_rd_addr;
  logic [EW-1:0]    ram_rd_data;

  logic             accept;
  logic             entry_hit;
  logic             dec_present;
  logic [ST_W-1:0]  dec_status;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign div_start = accept;
  assign entry_hit = ram_rd_data[KEY_W] && (ram_rd_data[KEY_W-1:0] == key_q);

  bhs_mod #(.NUM_BUCKETS(NUM_BUCKETS)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (s_tdata[KEY_W-1:0]),
    .done     (div_done),
    .rem      (bucket)
  );

  bhs_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // decision and slot write
  always_comb begin
    dec_present = hit_found;
    dec_status  = ST_DONE;
    ram_wr_en   = 1'b0;
    ram_wr_addr = clr_addr;
    ram_wr_data = '0;
    if (state == S_CLEAR) begin
      ram_wr_en = 1'b1;
    end else if (state == S_DECIDE) begin
      case (op_q)
        OP_INSERT: begin
          if (hit_found) begin
            dec_status = ST_DUPLICATE;
          end else if (!free_found) begin
            dec_status = ST_FULL;
          end else begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = base + AW'(free_idx);
            ram_wr_data = {1'b1, key_q};
          end
        end
        OP_DELETE: begin
          if (hit_found) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = base + AW'(hit_idx);
            ram_wr_data = {1'b0, key_q};
          end else begin
            dec_status = ST_ABSENT;
          end
        end
        default: dec_status = ST_DONE;  // query, and the unused code
      endcase
    end
  end

  assign ram_rd_en   = (state == S_SCAN) && (iss != CW'(BUCKET_DEPTH));
  assign ram_rd_addr = base + AW'(iss[IW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      m_tvalid   <= 1'b0;
      rd_pend    <= 1'b0;
      iss        <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      // a load in S_OUT takes precedence over the clear
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q  <= s_tuser;
            key_q <= s_tdata[KEY_W-1:0];
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            base       <= AW'(bucket) * AW'(BUCKET_DEPTH);
            iss        <= '0;
            rd_pend    <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pend <= ram_rd_en;
          rd_idx  <= iss[IW-1:0];
          if (ram_rd_en) begin
            iss <= iss + 1'b1;
          end
          if (rd_pend) begin
            if (entry_hit && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= rd_idx;
            end
            if (!ram_rd_data[KEY_W] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
          end
          if (!ram_rd_en && !rd_pend) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res_present <= dec_present;
          res_status  <= dec_status;
          state       <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'b0, res_status, res_present};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("request accepted while a request is in work");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (32'(bucket) < NUM_BUCKETS))
    else $error("bucket index out of range");

  a_dup_present: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && dec_status == ST_DUPLICATE) |-> dec_present)
    else $error("duplicate status without presence");

  a_full_absent: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && (dec_status == ST_FULL || dec_status == ST_ABSENT))
      |-> !dec_present)
    else $error("full or absent status with key present");

  a_no_write_scan: assert property (@(posedge clk) disable iff (rst)
    ram_rd_en |-> !ram_wr_en)
    else $error("slot write during bucket scan");

endmodule

// ===== test/tb_bucketed_hash_set_core.sv =====
`timescale 1ns / 1ps

import bhs_pkg::*;

typedef struct packed {
  logic            was_present;
  logic [ST_W-1:0] status;
} set_outcome_t;

class hash_set_scoreboard;
  localparam int NB    = NUM_BUCKETS_DEF;
  localparam int BD    = BUCKET_DEPTH_DEF;
  localparam int SLOTS = NB * BD;

  logic [KEY_W-1:0] slot_key[SLOTS];
  bit               slot_used[SLOTS];
  set_outcome_t     expected_outcomes[$];
  int               errors;
  int               checked;
  int               status_seen[4];

  function new();
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    errors  = 0;
    checked = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  endfunction

  function int pending();
    return expected_outcomes.size();
  endfunction

  // Applies one accepted request to the shadow set and queues its outcome.
  function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
    int base;
    int hit;
    int free;
    set_outcome_t o;
    base = int'(key % NB) * BD;
    hit  = -1;
    free = -1;
    for (int i = 0; i < BD; i++) begin
      if (slot_used[base+i] && slot_key[base+i] == key && hit < 0) hit = base + i;
      if (!slot_used[base+i] && free < 0) free = base + i;
    end
    o.was_present = (hit >= 0);
    o.status      = ST_DONE;
    case (op)
      OP_INSERT: begin
        if (hit >= 0) begin
          o.status = ST_DUPLICATE;
        end else if (free < 0) begin
          o.status = ST_FULL;
        end else begin
          slot_key[free]  = key;
          slot_used[free] = 1'b1;
        end
      end
      OP_DELETE: begin
        if (hit >= 0) slot_used[hit] = 1'b0;
        else o.status = ST_ABSENT;
      end
      default: ;  // query, and the spare code acts as a query
    endcase
    expected_outcomes.push_back(o);
  endfunction

  task report_mismatch(string msg);
    errors++;
    if (errors <= 20) $display("MISMATCH: %s", msg);
  endtask

  task check_result(logic [7:0] data);
    set_outcome_t want;
    logic            got_present;
    logic [ST_W-1:0] got_status;
    got_present = data[0];
    got_status  = data[2:1];
    if (expected_outcomes.size() == 0) begin
      report_mismatch($sformatf("unexpected result %02h", data));
    end else begin
      want = expected_outcomes.pop_front();
      checked++;
      status_seen[want.status]++;
      if (got_present !== want.was_present)
        report_mismatch($sformatf("result %0d: was_present %b, expected %b",
                                  checked, got_present, want.was_present));
      if (got_status !== want.status)
        report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                  checked, got_status, want.status));
    end
  endtask
endclass

module tb_bucketed_hash_set_core;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LATENCY      = BUCKET_DEPTH_DEF + 34;
  localparam int RANDOM_ITEMS = 480;
  localparam int POOL_SIZE    = 48;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // key[30:0], zero pad [31]
  logic [1:0]  s_tuser;   // op[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // was_present[0], status[2:1], zero pad [7:3]

  hash_set_scoreboard sb;
  int unsigned        cycles;
  int                 sent;
  int                 received;

  bucketed_hash_set_core #(
    .NUM_BUCKETS  (NUM_BUCKETS_DEF),
    .BUCKET_DEPTH (BUCKET_DEPTH_DEF)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
        $display("bucketed_hash_set_core verification failed");
        $finish;
      end
    end
  end

  // One request; the gap is drawn first so valid is never dropped and raised in one step.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    int gap;
    gap = ((sent / 37) % 3 == 1) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, key};
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, key);
    sent++;
  endtask

  // Result sink with random back-pressure.
  initial begin
    int gap;
    m_tready = 1'b0;
    received = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = ((received / 29) % 3 == 2) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata);
      received++;
    end
  end

  initial begin
    int               sel;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] key_pool[POOL_SIZE];
    sb       = new();
    sent     = 0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    rst      = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty set, duplicates, extreme keys, spare op code
    send_request(OP_QUERY,  '0);
    send_request(OP_DELETE, '0);
    send_request(OP_INSERT, '0);
    send_request(OP_INSERT, '0);
    send_request(OP_QUERY,  '0);
    send_request(OP_INSERT, '1);
    send_request(OP_SPARE,  '1);
    send_request(OP_SPARE,  KEY_W'(5));
    send_request(OP_DELETE, '1);
    send_request(OP_QUERY,  '1);
    // fill bucket 3, overflow it, then free a slot and reuse it
    for (int i = 0; i < BUCKET_DEPTH_DEF; i++) send_request(OP_INSERT, KEY_W'(3 + 10 * i));
    send_request(OP_INSERT, KEY_W'(83));
    send_request(OP_DELETE, KEY_W'(43));
    send_request(OP_INSERT, KEY_W'(83));
    send_request(OP_QUERY,  KEY_W'(83));
    send_request(OP_INSERT, 31'h5555_5555);
    send_request(OP_QUERY,  31'h2AAA_AAAA);

    // pool crowds four buckets so full buckets and hits stay frequent
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i < 36) begin
        key = KEY_W'($urandom);
        key = key - KEY_W'(key % 10) + KEY_W'(i % 4);
      end else begin
        key = KEY_W'($urandom_range(0, 200));
      end
      key_pool[i] = key;
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40)      op = OP_INSERT;
      else if (sel < 65) op = OP_DELETE;
      else if (sel < 90) op = OP_QUERY;
      else               op = OP_SPARE;
      if ($urandom_range(0, 9) == 0) key = KEY_W'($urandom);
      else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_request(op, key);
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    $display("%0d requests sent, %0d results checked in %0d cycles", sent, sb.checked, cycles);
    $display("outcomes: done %0d, duplicate %0d, absent %0d, bucket full %0d",
             sb.status_seen[ST_DONE], sb.status_seen[ST_DUPLICATE],
             sb.status_seen[ST_ABSENT], sb.status_seen[ST_FULL]);
    if (sb.errors == 0) begin
      $display("bucketed_hash_set_core verification clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("bucketed_hash_set_core verification failed");
    end
    $finish;
  end
endmodule
